// File: rtl/bounded_deque_with_reverse_core_assert.svh
// Assertion macros for the bounded deque core.
// Needs a clock named clk and a synchronous reset named rst in the including scope.
`ifndef BOUNDED_DEQUE_WITH_REVERSE_CORE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_REVERSE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdq check failed");

// Next-cycle implication, checked outside reset.
`define BDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdq check failed");

`endif

// File: rtl/bdq_pkg.sv
// Shared types and command codes for the bounded deque core.
// No dependencies.
package bdq_pkg;

  localparam int CMD_W = 3;
  localparam int RESULT_W = 16;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

  // Physical operation broadcast to every cell; front is cell 0.
  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic pop_back;
    logic clear;
  } cell_ctl_t;

endpackage

// File: rtl/bdq_cell.sv
// One storage cell of the deque chain: an element and its occupied bit.
// Depends on bdq_pkg (cell_ctl_t).
module bdq_cell #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bdq_pkg::cell_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_occ,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_occ,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  occ,
  output logic [DATA_WIDTH-1:0] tap
);

  logic [DATA_WIDTH-1:0] data_next;
  logic                  occ_next;

  always_comb begin
    data_next = data;
    occ_next  = occ;
    if (ctl.clear) begin
      occ_next = 1'b0;
    end else if (ctl.push_front) begin
      data_next = left_data;
      occ_next  = left_occ;
    end else if (ctl.pop_front) begin
      data_next = right_data;
      occ_next  = right_occ;
    end else if (ctl.push_back) begin
      // first free cell takes the value
      if (!occ && left_occ) begin
        data_next = push_data;
        occ_next  = 1'b1;
      end
    end else if (ctl.pop_back) begin
      occ_next = occ & right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // The last occupied cell drives its element onto the back read bus
  assign tap = (occ && !right_occ) ? data : '0;

endmodule

// File: rtl/bounded_deque_with_reverse_core.sv
// Top level of the bounded deque: command decode, counters and the cell chain.
// Depends on bdq_pkg, bdq_cell and bounded_deque_with_reverse_core_assert.svh.
//
//  channel   | signals                                          | handshake
//  ----------+--------------------------------------------------+-----------------------
//  command   | cmd, value                                       | start high, busy low
//  result    | popped_value, was_empty, was_full, element_count | done high for 1 cycle
//
// One command per clock; its result is shown on done in the next cycle.
// busy never rises: every command is one shift or load across the cell chain,
// and a back pop reads the last occupied cell through a bitwise OR bus.
// The receiver cannot stall, so results never wait.
// Reset clears the occupied bits, count, direction flag and done; cell data is not reset.
module bounded_deque_with_reverse_core #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 16,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [bdq_pkg::CMD_W-1:0]           cmd,
  input  logic signed [DATA_WIDTH-1:0]        value,
  output logic                                done,
  output logic signed [bdq_pkg::RESULT_W-1:0] popped_value,
  output logic                                was_empty,
  output logic                                was_full,
  output logic [CNT_W-1:0]                    element_count
);

  `include "bounded_deque_with_reverse_core_assert.svh"

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             reversed;
  logic             reversed_next;

  bdq_pkg::cell_ctl_t ctl;

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tap   [DEPTH];
  logic [DATA_WIDTH-1:0] left_data  [DEPTH];
  logic [DATA_WIDTH-1:0] right_data [DEPTH];
  logic [DEPTH-1:0]      cell_occ;
  logic [DEPTH-1:0]      left_occ;
  logic [DEPTH-1:0]      right_occ;
  logic [DATA_WIDTH-1:0] tail_data;

  logic accept;
  logic is_push;
  logic is_pop;
  logic at_front;
  logic is_empty;
  logic is_full;
  logic push_ok;
  logic pop_ok;
  logic [DATA_WIDTH-1:0] pop_data;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_empty = (count == '0);
  assign is_full  = (count == FULL_CNT);

  always_comb begin
    is_push  = 1'b0;
    is_pop   = 1'b0;
    at_front = 1'b0;
    unique case (cmd)
      bdq_pkg::CMD_PUSH_BACK: begin
        is_push  = 1'b1;
        at_front = reversed;
      end
      bdq_pkg::CMD_POP_BACK: begin
        is_pop   = 1'b1;
        at_front = reversed;
      end
      bdq_pkg::CMD_PUSH_FRONT: begin
        is_push  = 1'b1;
        at_front = !reversed;
      end
      bdq_pkg::CMD_POP_FRONT: begin
        is_pop   = 1'b1;
        at_front = !reversed;
      end
      default: begin
      end
    endcase
  end

  assign push_ok = accept && is_push && !is_full;
  assign pop_ok  = accept && is_pop && !is_empty;

  always_comb begin
    ctl.push_front = push_ok && at_front;
    ctl.push_back  = push_ok && !at_front;
    ctl.pop_front  = pop_ok && at_front;
    ctl.pop_back   = pop_ok && !at_front;
    ctl.clear      = accept && (cmd == bdq_pkg::CMD_CLEAR);
  end

  always_comb begin
    count_next    = count;
    reversed_next = reversed;
    if (ctl.clear) begin
      count_next    = '0;
      reversed_next = 1'b0;
    end else if (accept && (cmd == bdq_pkg::CMD_REVERSE)) begin
      reversed_next = !reversed;
    end else if (push_ok) begin
      count_next = count + CNT_W'(1);
    end else if (pop_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_data[i] = value;
      assign left_occ[i]  = 1'b1;
    end else begin : g_mid_l
      assign left_data[i] = cell_data[i-1];
      assign left_occ[i]  = cell_occ[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data[i] = cell_data[i];
      assign right_occ[i]  = 1'b0;
    end else begin : g_mid_r
      assign right_data[i] = cell_data[i+1];
      assign right_occ[i]  = cell_occ[i+1];
    end

    bdq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .push_data (value),
      .left_data (left_data[i]),
      .left_occ  (left_occ[i]),
      .right_data(right_data[i]),
      .right_occ (right_occ[i]),
      .data      (cell_data[i]),
      .occ       (cell_occ[i]),
      .tap       (cell_tap[i])
    );
  end

  // Only one cell drives a nonzero tap, so OR each bit across the chain
  for (genvar b = 0; b < DATA_WIDTH; b++) begin : g_bus
    logic [DEPTH-1:0] col;
    for (genvar i = 0; i < DEPTH; i++) begin : g_bit
      assign col[i] = cell_tap[i][b];
    end
    assign tail_data[b] = |col;
  end

  assign pop_data = at_front ? cell_data[0] : tail_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      reversed <= 1'b0;
      done     <= 1'b0;
    end else begin
      count    <= count_next;
      reversed <= reversed_next;
      done     <= accept;
    end
  end

  always_ff @(posedge clk) begin
    popped_value <= pop_ok ? bdq_pkg::RESULT_W'(signed'(pop_data)) : '0;
    was_empty    <= is_pop && is_empty;
    was_full     <= is_push && is_full;
  end

  assign element_count = count;

  `BDQ_ASSERT_NEXT(a_done_follows, accept, done)
  `BDQ_ASSERT_NEXT(a_no_spurious_done, !accept, !done)
  `BDQ_ASSERT_NOW(a_empty_gives_zero, done && was_empty, popped_value == '0)
  `BDQ_ASSERT_NOW(a_full_count, done && was_full, element_count == FULL_CNT)
  `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count <= FULL_CNT)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for bounded_deque_with_reverse_core: a directed table, then random traffic.
// Checks each result against its own deque predictor. Needs bdq_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD       = 10;
  localparam int DEPTH        = 64;
  localparam int NUM_DIR      = 25;
  localparam int RANDOM_ITEMS = 1880;
  localparam int STALL_LIMIT  = 500;

  // Codes the block decodes as no-ops.
  localparam logic [bdq_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [bdq_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic signed [15:0] pop_val;
    logic               empty;
    logic               full;
    logic [6:0]         count;
  } deque_result_t;

  typedef struct packed {
    logic [bdq_pkg::CMD_W-1:0] op;
    logic signed [15:0]        arg;
    logic                      typed;
    deque_result_t             want;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [bdq_pkg::CMD_W-1:0] cmd = '0;
  logic signed [15:0]        value = '0;
  logic                      busy;
  logic                      done;
  logic signed [15:0]        popped_value;
  logic                      was_empty;
  logic                      was_full;
  logic [6:0]                element_count;

  bounded_deque_with_reverse_core #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .value(value),
    .done(done),
    .popped_value(popped_value),
    .was_empty(was_empty),
    .was_full(was_full),
    .element_count(element_count)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Predictor state: circular slots, first-slot index, fill level, end swap.
  logic signed [15:0] slots [DEPTH];
  logic [5:0]         first_slot = '0;
  logic [6:0]         fill = '0;
  logic               flipped = 1'b0;

  deque_result_t pending_answers[$];
  int  mismatches = 0;
  int  checked = 0;
  bit  idle_on = 1'b1;
  int  n_push = 0, n_pop = 0, n_full = 0, n_empty = 0;
  int  n_rev = 0, n_clear = 0, n_spare = 0, peak_fill = 0;

  function automatic deque_result_t apply_deque_cmd(input logic [bdq_pkg::CMD_W-1:0] op,
                                                    input logic signed [15:0] arg);
    deque_result_t r;
    logic          at_first;
    r = '0;
    // Back-end operations land on the physical front once reversed.
    at_first = (op == bdq_pkg::CMD_PUSH_BACK || op == bdq_pkg::CMD_POP_BACK) ?
               flipped : !flipped;
    case (op)
      bdq_pkg::CMD_PUSH_BACK, bdq_pkg::CMD_PUSH_FRONT: begin
        n_push++;
        if (fill == 7'(DEPTH)) begin
          r.full = 1'b1;
          n_full++;
        end else begin
          if (at_first) begin
            first_slot = first_slot - 6'd1;
            slots[first_slot] = arg;
          end else begin
            slots[6'(first_slot + fill)] = arg;
          end
          fill++;
        end
      end
      bdq_pkg::CMD_POP_BACK, bdq_pkg::CMD_POP_FRONT: begin
        n_pop++;
        if (fill == 0) begin
          r.empty = 1'b1;
          n_empty++;
        end else begin
          if (at_first) begin
            r.pop_val = slots[first_slot];
            first_slot = first_slot + 6'd1;
          end else begin
            r.pop_val = slots[6'(first_slot + fill - 7'd1)];
          end
          fill--;
        end
      end
      bdq_pkg::CMD_REVERSE: begin
        flipped = !flipped;
        n_rev++;
      end
      bdq_pkg::CMD_CLEAR: begin
        first_slot = '0;
        fill = '0;
        flipped = 1'b0;
        n_clear++;
      end
      default: n_spare++;
    endcase
    if (fill > peak_fill) peak_fill = fill;
    r.count = fill;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_value();
    int k;
    k = $urandom_range(99);
    if (k < 3) return 16'sh7fff;
    if (k < 6) return 16'sh8000;
    if (k < 8) return 16'sh0000;
    if (k < 10) return 16'shffff;
    return 16'($urandom);
  endfunction

  function automatic logic [bdq_pkg::CMD_W-1:0] pick_side(input bit pushing);
    if (pushing) return $urandom_range(1) ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK;
    return $urandom_range(1) ? bdq_pkg::CMD_POP_FRONT : bdq_pkg::CMD_POP_BACK;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  // Enter at a falling edge; leave at the falling edge after the transaction.
  task automatic issue(input logic [bdq_pkg::CMD_W-1:0] op, input logic signed [15:0] arg,
                       input bit use_typed, input deque_result_t typed_res);
    deque_result_t r;
    while (idle_on && $urandom_range(99) < 6) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    value <= arg;
    do @(posedge clk); while (busy);
    r = apply_deque_cmd(op, arg);
    pending_answers.push_back(use_typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic issue_checked(input logic [bdq_pkg::CMD_W-1:0] op,
                               input logic signed [15:0] arg);
    issue(op, arg, 1'b0, '0);
  endtask

  // Hold the sender until every outstanding transaction has answered.
  task automatic drain();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        flag_mismatch("result with no pending transaction", 1, 0);
      end else begin
        want = pending_answers.pop_front();
        checked++;
        if (popped_value !== want.pop_val)
          flag_mismatch("popped_value", popped_value, want.pop_val);
        if (was_empty !== want.empty) flag_mismatch("was_empty", was_empty, want.empty);
        if (was_full !== want.full) flag_mismatch("was_full", was_full, want.full);
        if (element_count !== want.count)
          flag_mismatch("element_count", element_count, want.count);
      end
    end
  end

  // Watchdog: count cycles with neither a command nor a result moving.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog expired with %0d transactions outstanding",
               $realtime, pending_answers.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  dir_row_t dir_table [NUM_DIR];
  int       n_random = 0;

  initial begin
    int                        kind;
    int                        len;
    logic [bdq_pkg::CMD_W-1:0] op;

    dir_table = '{
      '{bdq_pkg::CMD_POP_BACK,   16'sh0000, 1'b1, '{16'sh0000, 1'b1, 1'b0, 7'd0}},
      '{bdq_pkg::CMD_POP_FRONT,  16'sh0000, 1'b1, '{16'sh0000, 1'b1, 1'b0, 7'd0}},
      '{bdq_pkg::CMD_PUSH_BACK,  16'sh7fff, 1'b1, '{16'sh0000, 1'b0, 1'b0, 7'd1}},
      '{bdq_pkg::CMD_PUSH_FRONT, 16'sh8000, 1'b1, '{16'sh0000, 1'b0, 1'b0, 7'd2}},
      '{bdq_pkg::CMD_PUSH_BACK,  16'sh0000, 1'b1, '{16'sh0000, 1'b0, 1'b0, 7'd3}},
      '{bdq_pkg::CMD_PUSH_FRONT, 16'shffff, 1'b1, '{16'sh0000, 1'b0, 1'b0, 7'd4}},
      '{bdq_pkg::CMD_POP_BACK,   16'sh0000, 1'b0, '0},
      '{bdq_pkg::CMD_POP_FRONT,  16'sh0000, 1'b0, '0},
      '{bdq_pkg::CMD_REVERSE,    16'sh1234, 1'b1, '{16'sh0000, 1'b0, 1'b0, 7'd2}},
      '{bdq_pkg::CMD_POP_BACK,   16'sh0000, 1'b0, '0},
      '{bdq_pkg::CMD_PUSH_BACK,  16'sh5555, 1'b0, '0},
      '{bdq_pkg::CMD_PUSH_FRONT, 16'shaaaa, 1'b0, '0},
      '{bdq_pkg::CMD_POP_FRONT,  16'sh0000, 1'b0, '0},
      '{bdq_pkg::CMD_REVERSE,    16'sh0000, 1'b0, '0},
      '{CMD_SPARE_6,             16'sh7fff, 1'b0, '0},
      '{CMD_SPARE_7,             16'sh8000, 1'b0, '0},
      '{bdq_pkg::CMD_CLEAR,      16'shffff, 1'b1, '{16'sh0000, 1'b0, 1'b0, 7'd0}},
      '{bdq_pkg::CMD_POP_FRONT,  16'sh0000, 1'b1, '{16'sh0000, 1'b1, 1'b0, 7'd0}},
      '{bdq_pkg::CMD_REVERSE,    16'sh0000, 1'b1, '{16'sh0000, 1'b0, 1'b0, 7'd0}},
      '{bdq_pkg::CMD_PUSH_BACK,  16'sh04d2, 1'b1, '{16'sh0000, 1'b0, 1'b0, 7'd1}},
      '{bdq_pkg::CMD_PUSH_FRONT, 16'shfb2e, 1'b1, '{16'sh0000, 1'b0, 1'b0, 7'd2}},
      '{bdq_pkg::CMD_POP_FRONT,  16'sh0000, 1'b0, '0},
      '{bdq_pkg::CMD_CLEAR,      16'sh0000, 1'b1, '{16'sh0000, 1'b0, 1'b0, 7'd0}},
      '{bdq_pkg::CMD_PUSH_FRONT, 16'sh0007, 1'b1, '{16'sh0000, 1'b0, 1'b0, 7'd1}},
      '{bdq_pkg::CMD_POP_BACK,   16'sh0000, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_table[i])
      issue(dir_table[i].op, dir_table[i].arg, dir_table[i].typed, dir_table[i].want);
    drain();

    while (n_random < RANDOM_ITEMS) begin
      // A quiet stretch with back-to-back transactions, and full drains midway.
      idle_on = !(n_random >= 700 && n_random < 1000);
      if (n_random >= 1000 && n_random < 1010) drain();
      kind = $urandom_range(99);
      if (kind < 8) begin
        // Fill to the top, bump the full case, then empty it past the bottom.
        while (fill != 7'(DEPTH)) begin
          issue_checked(pick_side(1'b1), pick_value());
          n_random++;
        end
        len = $urandom_range(3, 1);
        repeat (len) begin
          issue_checked(pick_side(1'b1), pick_value());
          n_random++;
        end
        if ($urandom_range(1)) begin
          issue_checked(bdq_pkg::CMD_REVERSE, pick_value());
          n_random++;
        end
        while (fill != 0) begin
          if ($urandom_range(9) == 0) issue_checked(bdq_pkg::CMD_REVERSE, pick_value());
          else issue_checked(pick_side(1'b0), pick_value());
          n_random++;
        end
        len = $urandom_range(2, 1);
        repeat (len) begin
          issue_checked(pick_side(1'b0), pick_value());
          n_random++;
        end
      end else if (kind < 14) begin
        // Noise: any code, spare ones included; spare codes do not count.
        len = $urandom_range(8, 1);
        repeat (len) begin
          op = bdq_pkg::CMD_W'($urandom_range(7));
          issue_checked(op, 16'($urandom));
          if (op != CMD_SPARE_6 && op != CMD_SPARE_7) n_random++;
        end
      end else begin
        len = $urandom_range(40, 5);
        repeat (len) begin
          kind = $urandom_range(99);
          if (kind < 45) op = pick_side(1'b1);
          else if (kind < 88) op = pick_side(1'b0);
          else if (kind < 97) op = bdq_pkg::CMD_REVERSE;
          else op = bdq_pkg::CMD_CLEAR;
          issue_checked(op, pick_value());
          n_random++;
        end
      end
    end

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d results: %0d pushes (%0d refused when full), %0d pops (%0d on empty),",
             checked, n_push, n_full, n_pop, n_empty);
    $display("  %0d reverses, %0d clears, %0d spare codes, peak fill %0d of %0d.",
             n_rev, n_clear, n_spare, peak_fill, DEPTH);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
